FILE: rtl/ddta_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, queue entry type and month-length lookup.
package ddta_pkg;

  // Field widths of the stream words
  localparam int DATE_W      = 19;
  localparam int TIME_W      = 18;
  localparam int OFFS_W      = 17;
  localparam int S_TDATA_W   = 56;
  localparam int M_TDATA_W   = 40;
  localparam int M_PAD_W     = M_TDATA_W - DATE_W - TIME_W;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Widths of the split decimal fields
  localparam int YEAR_W   = 7;
  localparam int MON_W    = 7;
  localparam int DAY_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 7;
  localparam int SEC_W    = 7;
  localparam int Q_D100_W = 13;
  localparam int Q_T100_W = 12;
  localparam int TOTAL_W  = 18;
  localparam int REM_W    = 17;
  localparam int Q60_W    = 11;
  localparam int DIGIT_W  = 6;

  // Reciprocals for exact constant division: q = (x * RECIP) >> SHIFT
  localparam logic [19:0] RECIP_100    = 20'd671089;
  localparam int          SHIFT_100    = 26;
  localparam logic [18:0] RECIP_10000  = 19'd429497;
  localparam int          SHIFT_10000  = 32;
  localparam logic [17:0] RECIP_3600   = 18'd149131;
  localparam int          SHIFT_3600   = 29;
  localparam logic [17:0] RECIP_60     = 18'd139811;
  localparam int          SHIFT_60     = 23;

  // Calendar and clock constants
  localparam logic [TOTAL_W-1:0] SECS_PER_DAY  = 18'd86400;
  localparam logic [TOTAL_W-1:0] SECS_TWO_DAYS = 18'd172800;
  localparam logic [TOTAL_W-1:0] SECS_PER_HOUR = 18'd3600;
  localparam logic [TOTAL_W-1:0] SECS_PER_MIN  = 18'd60;
  localparam logic [MON_W-1:0]   MONTH_FEB     = 7'd2;
  localparam logic [MON_W-1:0]   MONTHS_PER_YR = 7'd12;
  localparam logic [YEAR_W-1:0]  YEAR_WRAP     = 7'd100;
  localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 6'd29;
  localparam logic [DAY_W-1:0]   LONG_MONTH    = 6'd31;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    6'd31, 6'd28, 6'd31, 6'd30, 6'd31, 6'd30,
    6'd31, 6'd31, 6'd30, 6'd31, 6'd30, 6'd31
  };

  // One classified item held in the queue
  typedef struct packed {
    logic                 pass;   // zero offset: hand inputs straight through
    logic [DATE_W-1:0]    date;
    logic [TIME_W-1:0]    tod;
    logic [OFFS_W-1:0]    offs;
    logic [YEAR_W-1:0]    year;
    logic [MON_W-1:0]     mon;
    logic [DAY_W-1:0]     day;
    logic [HOUR_W-1:0]    hh;
    logic [MIN_W-1:0]     mm;
    logic [SEC_W-1:0]     ss;
  } entry_t;

  // Days in a month; unknown months count as long, February leaps on year mod 4
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                  input logic [YEAR_W-1:0] year);
    logic [3:0] idx;
    logic [MON_W-1:0] mon_m1;
    mon_m1 = mon - 7'd1;
    idx    = mon_m1[3:0];
    if (mon == '0 || mon > MONTHS_PER_YR) begin
      return LONG_MONTH;
    end else if (mon == MONTH_FEB && year[1:0] == 2'b00) begin
      return FEB_LEAP_DAYS;
    end else begin
      return MONTH_LEN[idx];
    end
  endfunction

endpackage

FILE: rtl/ddta_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, splits date and time into decimal fields.
module ddta_front #(
  parameter int QUEUE_DEPTH = ddta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ddta_pkg::S_TDATA_W-1:0]      s_tdata,  // date_ddmmyy, time_hhmmss, add_seconds
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count,
  output logic                                push,
  output ddta_pkg::entry_t                    push_data
);
  import ddta_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATE_W-1:0] date_in;
  logic [TIME_W-1:0] tod_in;
  logic [OFFS_W-1:0] offs_in;
  logic [CW:0]       used;
  logic              accept;

  logic [DATE_W+20-1:0] prod_d100;
  logic [DATE_W+19-1:0] prod_d10k;
  logic [TIME_W+20-1:0] prod_t100;
  logic [TIME_W+19-1:0] prod_t10k;

  // Stage one registers
  logic                v1;
  logic [DATE_W-1:0]   date1;
  logic [TIME_W-1:0]   tod1;
  logic [OFFS_W-1:0]   offs1;
  logic [Q_D100_W-1:0] d100;
  logic [DAY_W-1:0]    d10k;
  logic [Q_T100_W-1:0] t100;
  logic [HOUR_W-1:0]   t10k;

  logic [DATE_W-1:0]   year_full;
  logic [Q_D100_W-1:0] mon_full;
  logic [TIME_W-1:0]   ss_full;
  logic [Q_T100_W-1:0] mm_full;

  // Unpack the slave word
  assign date_in = s_tdata[DATE_W-1:0];
  assign tod_in  = s_tdata[DATE_W +: TIME_W];
  assign offs_in = s_tdata[DATE_W+TIME_W +: OFFS_W];

  // Admit a word only when the queue is sure to have room for it
  assign used     = {1'b0, q_count} + (CW+1)'(v1);
  assign s_tready = used < (CW+1)'(QUEUE_DEPTH);
  assign accept   = s_tvalid && s_tready;

  // Divide by 100 and 10000 through reciprocal multiplication
  assign prod_d100 = (DATE_W+20)'(date_in) * (DATE_W+20)'(RECIP_100);
  assign prod_d10k = (DATE_W+19)'(date_in) * (DATE_W+19)'(RECIP_10000);
  assign prod_t100 = (TIME_W+20)'(tod_in) * (TIME_W+20)'(RECIP_100);
  assign prod_t10k = (TIME_W+19)'(tod_in) * (TIME_W+19)'(RECIP_10000);

  // Hold the quotients for the next stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    if (accept) begin
      date1 <= date_in;
      tod1  <= tod_in;
      offs1 <= offs_in;
      d100  <= prod_d100[SHIFT_100 +: Q_D100_W];
      d10k  <= prod_d10k[SHIFT_10000 +: DAY_W];
      t100  <= prod_t100[SHIFT_100 +: Q_T100_W];
      t10k  <= prod_t10k[SHIFT_10000 +: HOUR_W];
    end
  end

  // Take remainders to get the two-digit fields
  assign year_full = date1 - DATE_W'(d100) * DATE_W'(100);
  assign mon_full  = d100 - Q_D100_W'(d10k) * Q_D100_W'(100);
  assign ss_full   = tod1 - TIME_W'(t100) * TIME_W'(100);
  assign mm_full   = t100 - Q_T100_W'(t10k) * Q_T100_W'(100);

  // Classify and push into the queue
  assign push = v1;
  always_comb begin
    push_data.pass = (offs1 == '0);
    push_data.date = date1;
    push_data.tod  = tod1;
    push_data.offs = offs1;
    push_data.year = year_full[YEAR_W-1:0];
    push_data.mon  = mon_full[MON_W-1:0];
    push_data.day  = d10k;
    push_data.hh   = t10k;
    push_data.mm   = mm_full[MIN_W-1:0];
    push_data.ss   = ss_full[SEC_W-1:0];
  end

endmodule

FILE: rtl/ddta_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of classified items between front and back.
module ddta_queue #(
  parameter int QUEUE_DEPTH = ddta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  ddta_pkg::entry_t                 push_data,
  input  logic                             pop,
  output logic                             q_valid,
  output ddta_pkg::entry_t                 q_data,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count
);
  import ddta_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign q_valid = (count != '0);
  assign q_count = count;
  assign q_data  = mem[rd_ptr];
  assign do_pop  = pop && q_valid;

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(do_pop);
    end
  end

endmodule

FILE: rtl/ddta_back.sv
`timescale 1ns / 1ps
// Back end: adds the offset, rolls the calendar and recodes date and time.
module ddta_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  ddta_pkg::entry_t              q_data,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ddta_pkg::M_TDATA_W-1:0] m_tdata  // new_date_ddmmyy, new_time_hhmmss, zero pad
);
  import ddta_pkg::*;

  logic adv;

  // Stage one: seconds since midnight plus offset
  logic               v1;
  entry_t             e1;
  logic [TOTAL_W-1:0] total1;
  logic [TOTAL_W-1:0] total_c;

  // Stage two: day carry and calendar roll
  logic               v2;
  logic               pass2;
  logic               keep2;
  logic [DATE_W-1:0]  date2;
  logic [TIME_W-1:0]  tod2;
  logic [REM_W-1:0]   rem2;
  logic [DAY_W-1:0]   day2;
  logic [MON_W-1:0]   mon2;
  logic [YEAR_W-1:0]  year2;
  logic [1:0]         carry_c;
  logic [TOTAL_W-1:0] rem_c;
  logic [DAY_W-1:0]   len_c;
  logic [DAY_W-1:0]   day_c;
  logic [MON_W-1:0]   mon_c;
  logic [YEAR_W-1:0]  year_c;

  // Stage three: hours and minutes quotient, date recoded
  logic               v3;
  logic               pass3;
  logic [TIME_W-1:0]  tod3;
  logic [DATE_W-1:0]  date3;
  logic [REM_W-1:0]   rem3;
  logic [HOUR_W-1:0]  h3;
  logic [Q60_W-1:0]   q60_3;
  logic [REM_W+18-1:0] prod3600;
  logic [REM_W+18-1:0] prod60;
  logic [DATE_W:0]    date_full;

  // Stage four: minute and second digits
  logic               v4;
  logic               pass4;
  logic [TIME_W-1:0]  tod4;
  logic [DATE_W-1:0]  date4;
  logic [HOUR_W-1:0]  h4;
  logic [DIGIT_W-1:0] mm4;
  logic [DIGIT_W-1:0] ss4;
  logic [Q60_W-1:0]   mm_full;
  logic [REM_W-1:0]   ss_full;

  // Output register
  logic [DATE_W-1:0]  date5;
  logic [TIME_W-1:0]  time5;
  logic [TIME_W-1:0]  time_c;

  // Move the whole pipe unless the output word is stalled
  assign adv = !(m_tvalid && !m_tready);
  assign pop = q_valid && adv;

  assign total_c = TOTAL_W'(q_data.hh) * SECS_PER_HOUR
                 + TOTAL_W'(q_data.mm) * SECS_PER_MIN
                 + TOTAL_W'(q_data.ss)
                 + TOTAL_W'(q_data.offs);

  // Reduce modulo one day and roll day, month and year
  always_comb begin
    if (total1 >= SECS_TWO_DAYS) begin
      carry_c = 2'd2;
      rem_c   = total1 - SECS_TWO_DAYS;
    end else if (total1 >= SECS_PER_DAY) begin
      carry_c = 2'd1;
      rem_c   = total1 - SECS_PER_DAY;
    end else begin
      carry_c = 2'd0;
      rem_c   = total1;
    end
    len_c  = month_days(e1.mon, e1.year);
    day_c  = e1.day + DAY_W'(carry_c);
    mon_c  = e1.mon;
    year_c = e1.year;
    if (day_c > len_c) begin
      day_c = day_c - len_c;
      mon_c = mon_c + 7'd1;
    end
    if (mon_c > MONTHS_PER_YR) begin
      mon_c  = mon_c - MONTHS_PER_YR;
      year_c = year_c + 7'd1;
      if (year_c >= YEAR_WRAP) begin
        year_c = '0;
      end
    end
  end

  assign prod3600  = (REM_W+18)'(rem2) * (REM_W+18)'(RECIP_3600);
  assign prod60    = (REM_W+18)'(rem2) * (REM_W+18)'(RECIP_60);
  assign date_full = (DATE_W+1)'(day2) * (DATE_W+1)'(10000)
                   + (DATE_W+1)'(mon2) * (DATE_W+1)'(100)
                   + (DATE_W+1)'(year2);

  assign mm_full = q60_3 - Q60_W'(h3) * Q60_W'(60);
  assign ss_full = rem3 - REM_W'(q60_3) * REM_W'(60);

  assign time_c = TIME_W'(h4) * TIME_W'(10000)
                + TIME_W'(mm4) * TIME_W'(100)
                + TIME_W'(ss4);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= q_valid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      m_tvalid <= v4;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      e1     <= q_data;
      total1 <= total_c;

      pass2  <= e1.pass;
      keep2  <= e1.pass || (carry_c == 2'd0);
      date2  <= e1.date;
      tod2   <= e1.tod;
      rem2   <= rem_c[REM_W-1:0];
      day2   <= day_c;
      mon2   <= mon_c;
      year2  <= year_c;

      pass3  <= pass2;
      tod3   <= tod2;
      date3  <= keep2 ? date2 : date_full[DATE_W-1:0];
      rem3   <= rem2;
      h3     <= prod3600[SHIFT_3600 +: HOUR_W];
      q60_3  <= prod60[SHIFT_60 +: Q60_W];

      pass4  <= pass3;
      tod4   <= tod3;
      date4  <= date3;
      h4     <= h3;
      mm4    <= mm_full[DIGIT_W-1:0];
      ss4    <= ss_full[DIGIT_W-1:0];

      date5  <= date4;
      time5  <= pass4 ? tod4 : time_c;
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, time5, date5};

endmodule

FILE: rtl/decimal_date_time_add_seconds.sv
`timescale 1ns / 1ps
// Top level: adds an offset in seconds to a decimal-coded UTC date and time.
// Each slave word carries a DDMMYY date, an HHMMSS time and an offset of
// seconds; each master word returns the advanced date and time in the same
// decimal coding. The block takes one word per clock and returns one word
// per clock, in order, while the master side is ready. A front end splits
// the decimal fields through reciprocal multipliers, a queue of QUEUE_DEPTH
// entries (at least three for full rate) separates it from a five-stage
// back end that adds the offset, rolls day, month and year, and recodes
// the result. A stalled master side holds the back end; the front end
// keeps taking words until the queue is full. Year 99 rolls over to 00.
module decimal_date_time_add_seconds #(
  parameter int QUEUE_DEPTH = ddta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ddta_pkg::S_TDATA_W-1:0] s_tdata,  // date_ddmmyy, time_hhmmss, add_seconds
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ddta_pkg::M_TDATA_W-1:0] m_tdata   // new_date_ddmmyy, new_time_hhmmss
);
  import ddta_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          push;
  entry_t        push_data;
  logic          pop;
  logic          q_valid;
  entry_t        q_data;
  logic [CW-1:0] q_count;

  ddta_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  ddta_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_count   (q_count)
  );

  ddta_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: tb/tb_decimal_date_time_add_seconds.sv
`timescale 1ns / 1ps
// Self-checking bench for the decimal date/time adder: directed, random and back-pressure runs.
module tb_decimal_date_time_add_seconds;
  import ddta_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [DATE_W-1:0] date;
    logic [TIME_W-1:0] tod;
  } stamp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // date_ddmmyy, time_hhmmss, add_seconds
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // new_date_ddmmyy, new_time_hhmmss

  stamp_t due_stamps[$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  bit     tx_idle = 1'b1;
  bit     rx_idle = 1'b1;
  int     hold_req = 0;

  decimal_date_time_add_seconds u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Days in a month; unknown months count as 31, February leaps when year mod 4 is zero
  function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
    if (mo == 0 || mo > 12) return 31;
    case (mo)
      2:       return (yr % 4 == 0) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Advance a decimal-coded date and time by a number of seconds
  function automatic stamp_t advance_timestamp(input logic [DATE_W-1:0] d,
                                               input logic [TIME_W-1:0] t,
                                               input logic [OFFS_W-1:0] o);
    stamp_t      r;
    int unsigned yr, mo, dy, hh, mm, ss, total, carry, mlen;
    r.date = d;
    r.tod  = t;
    if (o == '0) return r;
    yr = d % 100;
    mo = (d / 100) % 100;
    dy = (d / 10000) % 100;
    ss = t % 100;
    mm = (t / 100) % 100;
    hh = (t / 10000) % 100;
    total = hh * 3600 + mm * 60 + ss + o;
    carry = total / 86400;
    total = total % 86400;
    r.tod = TIME_W'((total / 3600) * 10000 + ((total / 60) % 60) * 100 + total % 60);
    if (carry == 0) return r;
    // roll the day once, then the month and year once each
    mlen = month_length(mo, yr);
    dy = dy + carry;
    if (dy > mlen) begin
      dy = dy - mlen;
      mo = mo + 1;
    end
    if (mo > 12) begin
      mo = mo - 12;
      yr = yr + 1;
      if (yr >= 100) yr = 0;
    end
    r.date = DATE_W'(dy * 10000 + mo * 100 + yr);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] want,
                                 input logic [39:0] got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic [DATE_W-1:0] d, input logic [TIME_W-1:0] t,
                           input logic [OFFS_W-1:0] o);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - DATE_W - TIME_W - OFFS_W){1'b0}}, o, t, d};
    do @(posedge clk); while (!s_tready);
  endtask

  // Pick a well-formed timestamp, biased towards month ends and late evening
  task automatic pick_calendar_word(output logic [DATE_W-1:0] d,
                                    output logic [TIME_W-1:0] t,
                                    output logic [OFFS_W-1:0] o);
    int unsigned yr, mo, dy, hh, mm, ss, sel;
    yr = $urandom_range(0, 99);
    mo = $urandom_range(1, 12);
    dy = ($urandom_range(0, 2) == 0) ? month_length(mo, yr)
                                     : $urandom_range(1, month_length(mo, yr));
    if ($urandom_range(0, 3) == 0) begin
      hh = 23;
      mm = 59;
    end else begin
      hh = $urandom_range(0, 23);
      mm = $urandom_range(0, 59);
    end
    ss = $urandom_range(0, 59);
    d = DATE_W'(dy * 10000 + mo * 100 + yr);
    t = TIME_W'(hh * 10000 + mm * 100 + ss);
    sel = $urandom_range(0, 9);
    case (sel)
      0:       o = '0;
      1:       o = OFFS_W'(86399);
      2, 3:    o = OFFS_W'($urandom_range(1, 120));
      default: o = OFFS_W'($urandom_range(1, 86399));
    endcase
  endtask

  // Mostly well-formed timestamps, with a share of raw bit noise
  task automatic run_mixed_words(input int n);
    logic [DATE_W-1:0] d;
    logic [TIME_W-1:0] t;
    logic [OFFS_W-1:0] o;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        d = DATE_W'($urandom);
        t = TIME_W'($urandom);
        o = OFFS_W'($urandom);
      end else begin
        pick_calendar_word(d, t, o);
      end
      send_word(d, t, o);
    end
  endtask

  // Field extremes and the calendar corner cases
  task automatic run_directed;
    send_word(19'h7FFFF, 18'h3FFFF, 17'd0);       // zero offset passes raw bits through
    send_word(19'd150623, 18'd101010, 17'd0);     // zero offset, ordinary stamp
    send_word(19'd0, 18'd0, 17'd1);               // all-zero date and time
    send_word(19'd10100, 18'd0, 17'd86399);       // no day overflow
    send_word(19'd10199, 18'd0, 17'd86399);       // midnight plus almost a day
    send_word(19'd310199, 18'd235959, 17'd1);     // end of a long month
    send_word(19'd300499, 18'd235959, 17'd1);     // end of a short month
    send_word(19'd280224, 18'd120000, 17'd86399); // leap February keeps day 29
    send_word(19'd290224, 18'd235959, 17'd1);     // leap February ends
    send_word(19'd280223, 18'd235959, 17'd1);     // common February ends
    send_word(19'd311299, 18'd235959, 17'd1);     // year 99 wraps to 00
    send_word(19'd310099, 18'd235959, 17'd1);     // month zero counts as long
    send_word(19'd151399, 18'd120000, 17'd86399); // month thirteen rolls the year
    send_word(19'd450100, 18'd235959, 17'd1);     // day still too large after carry
    send_word(19'd100550, 18'd255959, 17'h1FFFF); // oversized hour and offset, two days
    send_word(19'd150650, 18'd129999, 17'd1);     // minutes and seconds above 59
    send_word(19'd311299, 18'd235959, 17'h1FFFF); // two-day carry over the new year
    send_word(19'd521299, 18'd235959, 17'h1FFFF); // largest day the field can hold
    send_word(19'h7FFFF, 18'h3FFFF, 17'h1FFFF);   // every input bit set
    send_word(19'd0, 18'd0, 17'h1FFFF);           // offset alone carries a day
    send_word(19'd120699, 18'd235959, 17'd86399);
  endtask

  // Random traffic with gaps and stalls on both sides
  task automatic run_idle_traffic;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_mixed_words(880);
  endtask

  // A stretch with no idling at all
  task automatic run_full_rate;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_mixed_words(150);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Hold the master side off long enough for the block to stall its input
  task automatic run_backpressure;
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 300;
    run_mixed_words(48);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Receiver: random stall before each word, or a long hold-off on request
  initial begin : receiver
    int w;
    while (rst) @(negedge clk);
    forever begin
      w = rx_idle ? $urandom_range(0, 16) : 0;
      if (hold_req > 0) begin
        w = hold_req;
        hold_req = 0;
      end
      repeat (w) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Predict every accepted slave word
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      due_stamps.push_back(advance_timestamp(s_tdata[0 +: DATE_W],
                                             s_tdata[DATE_W +: TIME_W],
                                             s_tdata[DATE_W + TIME_W +: OFFS_W]));
    end
  end

  // Compare every accepted master word with the oldest prediction
  always @(posedge clk) begin : check_results
    stamp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_stamps.size() == 0) begin
        report_mismatch("word with nothing due", '0, m_tdata);
      end else begin
        want = due_stamps.pop_front();
        if (m_tdata[0 +: DATE_W] !== want.date)
          report_mismatch("new_date_ddmmyy", 40'(want.date), 40'(m_tdata[0 +: DATE_W]));
        if (m_tdata[DATE_W +: TIME_W] !== want.tod)
          report_mismatch("new_time_hhmmss", 40'(want.tod), 40'(m_tdata[DATE_W +: TIME_W]));
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_idle_traffic();
    run_backpressure();
    run_full_rate();
    @(negedge clk);
    s_tvalid <= 1'b0;
    // drain what is still in flight, then watch for stray words
    while (due_stamps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
